>>> rtl/lsau_pkg.sv
// ----------------------------------------------------------------------------
// lsau_pkg
// Shared command codes and item types of the load/store align unit.
// ----------------------------------------------------------------------------
package lsau_pkg;

    localparam logic [3:0] CMD_LB  = 4'd0;
    localparam logic [3:0] CMD_LBU = 4'd1;
    localparam logic [3:0] CMD_LH  = 4'd2;
    localparam logic [3:0] CMD_LHU = 4'd3;
    localparam logic [3:0] CMD_LUI = 4'd4;
    localparam logic [3:0] CMD_LW  = 4'd5;
    localparam logic [3:0] CMD_LWL = 4'd6;
    localparam logic [3:0] CMD_LWR = 4'd7;
    localparam logic [3:0] CMD_SB  = 4'd8;
    localparam logic [3:0] CMD_SH  = 4'd9;
    localparam logic [3:0] CMD_SW  = 4'd10;
    localparam logic [3:0] CMD_SWL = 4'd11;
    localparam logic [3:0] CMD_SWR = 4'd12;

    localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]         command;
        logic [31:0]        base_value;
        logic signed [15:0] imm_offset;
        logic [31:0]        rt_value;
        logic [31:0]        mem_word;
        logic               mem_fault;
    } req_t;

    typedef struct packed {
        logic [31:0] eff_address;
        logic        reg_write;
        logic [31:0] reg_result;
        logic        mem_write;
        logic [31:0] store_word;
        logic [3:0]  byte_enable;
    } rsp_t;

    // Item after the address add.
    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] eff_address;
        logic [15:0] imm_offset;
        logic [31:0] rt_value;
        logic [31:0] mem_word;
        logic        mem_fault;
    } addr_item_t;

    // Item after lane shifting: every candidate word is ready for selection.
    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] eff_address;
        logic [15:0] imm_offset;
        logic        mem_fault;
        logic [31:0] mem_byte;
        logic [31:0] mem_half;
        logic [31:0] mem_full;
        logic [31:0] lwl_word;
        logic [31:0] lwr_word;
        logic [31:0] store_data;
        logic [3:0]  byte_enable;
    } lane_item_t;

endpackage

>>> rtl/lsau_addr_stage.sv
// ----------------------------------------------------------------------------
// lsau_addr_stage
// First pipeline stage: forms the effective address.
// ----------------------------------------------------------------------------
module lsau_addr_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  lsau_pkg::req_t       up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output lsau_pkg::addr_item_t dn_data
);

    logic                 valid_reg;
    lsau_pkg::addr_item_t data_reg;
    lsau_pkg::addr_item_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.command     = up_data.command;
        data_next.eff_address = up_data.base_value
                              + {{16{up_data.imm_offset[15]}}, up_data.imm_offset};
        data_next.imm_offset  = up_data.imm_offset;
        data_next.rt_value    = up_data.rt_value;
        data_next.mem_word    = up_data.mem_word;
        data_next.mem_fault   = up_data.mem_fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/lsau_lane_stage.sv
// ----------------------------------------------------------------------------
// lsau_lane_stage
// Second pipeline stage: byte lane shifts, LWL/LWR merges, store data
// placement and byte enables.
// ----------------------------------------------------------------------------
module lsau_lane_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  lsau_pkg::addr_item_t up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output lsau_pkg::lane_item_t dn_data
);

    logic                 valid_reg;
    lsau_pkg::lane_item_t data_reg;
    lsau_pkg::lane_item_t data_next;

    logic [1:0] lane;
    logic [4:0] byte_shift;
    logic [4:0] half_shift;
    logic [4:0] left_shift;
    logic [4:0] swl_mask;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign lane       = up_data.eff_address[1:0];
    assign byte_shift = {lane, 3'b000};
    assign half_shift = {lane[1], 4'b0000};
    assign left_shift = {~lane, 3'b000};
    assign swl_mask   = (5'd2 << lane) - 5'd1;

    always_comb
    begin
        data_next.command     = up_data.command;
        data_next.eff_address = up_data.eff_address;
        data_next.imm_offset  = up_data.imm_offset;
        data_next.mem_fault   = up_data.mem_fault;
        data_next.mem_byte    = up_data.mem_word >> byte_shift;
        data_next.mem_half    = up_data.mem_word >> half_shift;
        data_next.mem_full    = up_data.mem_word;
        data_next.lwl_word    = (up_data.mem_word << left_shift)
                              | (up_data.rt_value & ~(lsau_pkg::FULL_WORD << left_shift));
        data_next.lwr_word    = (up_data.mem_word >> byte_shift)
                              | (up_data.rt_value & ~(lsau_pkg::FULL_WORD >> byte_shift));
        data_next.store_data  = 32'd0;
        data_next.byte_enable = 4'd0;

        unique case (up_data.command)
            lsau_pkg::CMD_SB:
            begin
                data_next.store_data  = {24'd0, up_data.rt_value[7:0]} << byte_shift;
                data_next.byte_enable = 4'b0001 << lane;
            end
            lsau_pkg::CMD_SH:
            begin
                data_next.store_data  = {16'd0, up_data.rt_value[15:0]} << half_shift;
                data_next.byte_enable = 4'b0011 << {lane[1], 1'b0};
            end
            lsau_pkg::CMD_SW:
            begin
                data_next.store_data  = up_data.rt_value;
                data_next.byte_enable = 4'b1111;
            end
            lsau_pkg::CMD_SWL:
            begin
                data_next.store_data  = up_data.rt_value >> left_shift;
                data_next.byte_enable = swl_mask[3:0];
            end
            lsau_pkg::CMD_SWR:
            begin
                data_next.store_data  = up_data.rt_value << byte_shift;
                data_next.byte_enable = 4'b1111 << lane;
            end
            default:
            begin
                data_next.store_data  = 32'd0;
                data_next.byte_enable = 4'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/lsau_result_stage.sv
// ----------------------------------------------------------------------------
// lsau_result_stage
// Third pipeline stage: result selection, sign or zero extension, fault
// masking and the output register.
// ----------------------------------------------------------------------------
module lsau_result_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  lsau_pkg::lane_item_t up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output lsau_pkg::rsp_t       dn_data
);

    logic           valid_reg;
    lsau_pkg::rsp_t data_reg;
    lsau_pkg::rsp_t data_next;

    logic        load_hit;
    logic [31:0] load_value;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        load_hit   = 1'b1;
        load_value = 32'd0;
        unique case (up_data.command)
            lsau_pkg::CMD_LB:  load_value = {{24{up_data.mem_byte[7]}}, up_data.mem_byte[7:0]};
            lsau_pkg::CMD_LBU: load_value = {24'd0, up_data.mem_byte[7:0]};
            lsau_pkg::CMD_LH:  load_value = {{16{up_data.mem_half[15]}}, up_data.mem_half[15:0]};
            lsau_pkg::CMD_LHU: load_value = {16'd0, up_data.mem_half[15:0]};
            lsau_pkg::CMD_LUI: load_value = {up_data.imm_offset, 16'd0};
            lsau_pkg::CMD_LW:  load_value = up_data.mem_full;
            lsau_pkg::CMD_LWL: load_value = up_data.lwl_word;
            lsau_pkg::CMD_LWR: load_value = up_data.lwr_word;
            default:           load_hit   = 1'b0;
        endcase

        // A faulting memory load leaves rt alone; LUI never touches memory.
        if (up_data.mem_fault && up_data.command != lsau_pkg::CMD_LUI)
        begin
            load_hit = 1'b0;
        end

        data_next.eff_address = up_data.eff_address;
        data_next.reg_write   = load_hit;
        data_next.reg_result  = load_hit ? load_value : 32'd0;
        data_next.mem_write   = (up_data.byte_enable != 4'd0);
        data_next.store_word  = up_data.store_data;
        data_next.byte_enable = up_data.byte_enable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/load_store_align_unit.sv
// ----------------------------------------------------------------------------
// load_store_align_unit
// Little-endian MIPS I load/store alignment datapath, three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_ready, req_data) takes one memory
//   instruction item: command, base, offset, old rt, aligned memory word and
//   fault flag. The response channel (rsp_valid, rsp_ready, rsp_data) gives
//   the effective address, the rt write and the aligned store word with its
//   byte enables for that item.
//   An accepted item passes through three registered stages before rsp_valid:
//   address add, lane shift and merge, then result selection in the output register.
//   Throughput is one item per cycle while rsp_ready stays high; each stage holds one item and passes it
//   on whenever the next stage is empty or moving.
//   When the receiver stalls, items stay in their stages and req_ready falls
//   only once all three stages are full; no item is dropped or repeated.
//   Reset clears the stage valid bits, so the pipeline starts empty and
//   req_ready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module load_store_align_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lsau_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lsau_pkg::rsp_t rsp_data
);

    logic                 addr_valid;
    logic                 addr_ready;
    lsau_pkg::addr_item_t addr_data;
    logic                 lane_valid;
    logic                 lane_ready;
    lsau_pkg::lane_item_t lane_data;

    lsau_addr_stage u_addr (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .up_data  (req_data),
        .dn_valid (addr_valid),
        .dn_ready (addr_ready),
        .dn_data  (addr_data)
    );

    lsau_lane_stage u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (addr_valid),
        .up_ready (addr_ready),
        .up_data  (addr_data),
        .dn_valid (lane_valid),
        .dn_ready (lane_ready),
        .dn_data  (lane_data)
    );

    lsau_result_stage u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lane_valid),
        .up_ready (lane_ready),
        .up_data  (lane_data),
        .dn_valid (rsp_valid),
        .dn_ready (rsp_ready),
        .dn_data  (rsp_data)
    );

endmodule
